>>> src/idde_pkg.sv
// Package for the disk density evaluator: field widths, register codes,
// the exponential table function and the structs passed between modules.
// Used by every module in src; no dependencies of its own.
`default_nettype none
package idde_pkg;
  localparam int unsigned ImageWidth   = 256;
  localparam int unsigned ImageHeight  = 256;
  localparam int unsigned ExpTableSize = 256;
  localparam int unsigned ExpSpan      = 16;
  localparam int unsigned ExpIdxW      = $clog2(ExpTableSize);
  localparam int unsigned AddrW        = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned PixW         = 32;
  localparam int unsigned DensW        = 48;
  localparam int unsigned InW          = 1 + 16 + 32 + 3 * 32;
  localparam int unsigned InDataW      = ((InW - 1 + 7) / 8) * 8;
  localparam int unsigned OutDataW     = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegSinAngle   = 3'd0,
    RegCosAngle   = 3'd1,
    RegCosTilt    = 3'd2,
    RegInvPixel   = 3'd3,
    RegCenterCol  = 3'd4,
    RegCenterRow  = 3'd5,
    RegInvHeight  = 3'd6,
    RegDensNorm   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
    logic [14:0]        cos_tilt;
    logic [31:0]        inv_pixel_size;
    logic [24:0]        center_col;
    logic [24:0]        center_row;
    logic [31:0]        inv_height_scale;
    logic [31:0]        density_norm;
  } cfg_t;

  // queued command between the front and the back
  typedef struct packed {
    logic              is_query;
    logic              in_image;
    logic [AddrW-1:0]  addr;
    logic [PixW-1:0]   wdata;
    logic [ExpIdxW-1:0] eidx;
    logic [31:0]       efrac;
    logic              ezero;
  } cmd_t;

  // exponential table entries, Q1.32 in 33 bits
  function automatic logic [32:0] exp_entry(input int unsigned i);
    logic [63:0] step, h, sum, term, r, e;
    step = (64'(ExpSpan) << 32) / 64'(ExpTableSize);
    h = step >> 1;
    sum = 64'd1 << 32;
    term = sum;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * h) >> 32) / 64'(k);
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum * sum + 64'h8000_0000) >> 32;
    e = 64'd1 << 32;
    for (int unsigned k = 1; k <= i; k++) e = (e * r + 64'h8000_0000) >> 32;
    return e[32:0];
  endfunction
endpackage
`default_nettype wire

>>> src/image_disk_density_eval.sv
// Top level of the disk density evaluator: configuration registers and the
// front, queue and back instances. Depends on idde_pkg and the idde_* modules.
//
// Usage: load the pixel store with write transfers (func 0) before any query
// reads those pixels. Query transfers (func 1) return one result each;
// writes return density 0 and inside 0. Every input transfer yields exactly
// one output transfer, in order.
// Pipeline: ten register stages, 5 in the front, 1 queue slot and 4 in the
// back (store read, interpolation, pixel product, normalisation product).
// Throughput is one item per cycle while the receiver does not stall: every
// stage is pipelined and each item touches the store once.
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills and then the front holds; s_axis_tready drops only then.
// Reset clears pipeline valid bits and loads default register values; the
// pixel store is undefined until written.
// Configuration writes take effect immediately and are accepted always.
`default_nettype none
module image_disk_density_eval (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: pixel_addr[15:0], pixel_value[47:16], pos_x[79:48],
  // pos_y[111:80], pos_z[143:112]
  input  wire logic [143:0] s_axis_tdata,
  // tuser: func
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: density[47:0]
  output logic [47:0]       m_axis_tdata,
  // tuser: inside_res
  output logic              m_axis_tuser
);
  idde_pkg::cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_angle        <= 16'sd0;
      cfg_q.cos_angle        <= 16'sd16384;
      cfg_q.cos_tilt         <= 15'd16384;
      cfg_q.inv_pixel_size   <= 32'd65536;
      cfg_q.center_col       <= 25'd8388608;
      cfg_q.center_row       <= 25'd8388608;
      cfg_q.inv_height_scale <= 32'd65536;
      cfg_q.density_norm     <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (idde_pkg::reg_idx_e'(cfg_index_i))
        idde_pkg::RegSinAngle:  cfg_q.sin_angle        <= cfg_data_i[15:0];
        idde_pkg::RegCosAngle:  cfg_q.cos_angle        <= cfg_data_i[15:0];
        idde_pkg::RegCosTilt:   cfg_q.cos_tilt         <= cfg_data_i[14:0];
        idde_pkg::RegInvPixel:  cfg_q.inv_pixel_size   <= cfg_data_i;
        idde_pkg::RegCenterCol: cfg_q.center_col       <= cfg_data_i[24:0];
        idde_pkg::RegCenterRow: cfg_q.center_row       <= cfg_data_i[24:0];
        idde_pkg::RegInvHeight: cfg_q.inv_height_scale <= cfg_data_i;
        idde_pkg::RegDensNorm:  cfg_q.density_norm     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic fv, fr, bv, br;
  idde_pkg::cmd_t fc, bc;
  idde_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tuser), .addr_i(s_axis_tdata[15:0]),
    .wdata_i(s_axis_tdata[47:16]), .pos_x_i(s_axis_tdata[79:48]),
    .pos_y_i(s_axis_tdata[111:80]), .pos_z_i(s_axis_tdata[143:112]),
    .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fc)
  );
  idde_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fc),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bc)
  );
  idde_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(bv), .cmd_ready_o(br),
    .cmd_i(bc), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .density_o(m_axis_tdata), .inside_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

>>> src/idde_front.sv
// Front end: applies rotation and pixel mapping to queries, computes the
// exponential table index, and emits commands. Depends on idde_pkg.
`default_nettype none
module idde_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire idde_pkg::cfg_t cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           func_i,
  input  wire logic [15:0]    addr_i,
  input  wire logic [31:0]    wdata_i,
  input  wire logic [31:0]    pos_x_i,
  input  wire logic [31:0]    pos_y_i,
  input  wire logic [31:0]    pos_z_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output idde_pkg::cmd_t      cmd_o
);
  localparam int unsigned NS = 5;
  logic [NS-1:0] v_q;
  logic          adv;
  assign adv        = !v_q[NS-1] || cmd_ready_i;
  assign in_ready_o = adv;
  assign cmd_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-2:0], in_valid_i};
  end

  // stage 1: tilt, |z| * scale
  logic                q1_q, q2_q, q3_q, q4_q;
  logic [15:0]         a1_q, a2_q, a3_q, a4_q;
  logic [31:0]         w1_q, w2_q, w3_q, w4_q;
  logic signed [47:0]  xp_q;
  logic signed [31:0]  y1_q;
  logic [63:0]         t_q, t2_q, t3_q, t4_q;
  logic signed [63:0]  xp_full;
  logic [31:0]         az;
  assign xp_full = $signed(pos_x_i) * $signed({1'b0, cfg_i.cos_tilt});
  assign az = pos_z_i[31] ? 32'(-pos_z_i) : pos_z_i;

  // stage 2: four products
  logic signed [63:0] sx_q, cy_q, sy_q, cx_q;
  // stage 3: rotated coords
  logic signed [63:0] xr_s, yr_s;
  logic signed [49:0] xr_q, yr_q;
  // stage 4: pixel mapping partial products
  logic signed [63:0] ch_q, cl_q, rh_q, rl_q;
  logic signed [63:0] cacc, racc;
  logic signed [47:0] col, row;
  logic               in_img;
  logic [15:0]        hi, lo;
  assign hi = cfg_i.inv_pixel_size[31:16];
  assign lo = cfg_i.inv_pixel_size[15:0];
  assign xr_s = (sx_q + cy_q) >>> 14;
  assign yr_s = (sy_q - cx_q) >>> 14;
  assign cacc = ch_q + $signed({39'd0, cfg_i.center_col}) + (cl_q >>> 16);
  assign racc = rh_q + $signed({39'd0, cfg_i.center_row}) + (rl_q >>> 16);
  assign col = 48'(cacc >>> 16);
  assign row = 48'(racc >>> 16);
  assign in_img = !col[47] && !row[47] && (col < 48'(idde_pkg::ImageWidth))
                  && (row < 48'(idde_pkg::ImageHeight));
  logic [63:0] pos;
  logic [63:0] addr_w;
  assign pos    = (t4_q * 64'(idde_pkg::ExpTableSize)) / 64'(idde_pkg::ExpSpan);
  assign addr_w = 64'(col) + 64'(idde_pkg::ImageWidth) * 64'(row);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q1_q <= func_i; a1_q <= addr_i; w1_q <= wdata_i;
      xp_q <= 48'(xp_full >>> 14); y1_q <= $signed(pos_y_i);
      t_q  <= 64'(az) * 64'(cfg_i.inv_height_scale);
      q2_q <= q1_q; a2_q <= a1_q; w2_q <= w1_q; t2_q <= t_q;
      sx_q <= 64'(cfg_i.sin_angle * xp_q);
      cy_q <= 64'(cfg_i.cos_angle * y1_q);
      sy_q <= 64'(cfg_i.sin_angle * y1_q);
      cx_q <= 64'(cfg_i.cos_angle * xp_q);
      q3_q <= q2_q; a3_q <= a2_q; w3_q <= w2_q; t3_q <= t2_q;
      xr_q <= 50'(xr_s); yr_q <= 50'(yr_s);
      q4_q <= q3_q; a4_q <= a3_q; w4_q <= w3_q; t4_q <= t3_q;
      ch_q <= 64'(xr_q * $signed({1'b0, hi}));
      cl_q <= 64'(xr_q * $signed({1'b0, lo}));
      rh_q <= 64'(yr_q * $signed({1'b0, hi}));
      rl_q <= 64'(yr_q * $signed({1'b0, lo}));
      cmd_o.is_query <= q4_q;
      cmd_o.in_image <= in_img;
      cmd_o.addr     <= q4_q ? addr_w[15:0] : a4_q;
      cmd_o.wdata    <= w4_q;
      cmd_o.eidx     <= pos[32 +: idde_pkg::ExpIdxW];
      cmd_o.efrac    <= pos[31:0];
      cmd_o.ezero    <= t4_q >= (64'(idde_pkg::ExpSpan) << 32);
    end
  end
endmodule
`default_nettype wire

>>> src/idde_fifo.sv
// Short command queue decoupling front and back ends.
// Depends on idde_pkg.
`default_nettype none
module idde_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire idde_pkg::cmd_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output idde_pkg::cmd_t      rd_data_o
);
  idde_pkg::cmd_t mem_q [4];
  logic [2:0] wp_q, rp_q;
  logic wr, rd;
  assign wr_ready_o = (wp_q - rp_q) != 3'd4;
  assign rd_valid_o = wp_q != rp_q;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q[1:0]];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 3'd1;
      if (rd) rp_q <= rp_q + 3'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q[1:0]] <= wr_data_i;
  end
endmodule
`default_nettype wire

>>> src/idde_back.sv
// Back end: pixel store, exponential interpolation, product and output
// register. Depends on idde_pkg.
`default_nettype none
module idde_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire idde_pkg::cfg_t cfg_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire idde_pkg::cmd_t cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [47:0]         density_o,
  output logic                inside_o
);
  localparam int unsigned NS = 4;
  logic [NS-1:0] v_q;
  logic adv;
  assign adv = !v_q[NS-1] || out_ready_i;
  assign cmd_ready_o = adv;
  assign out_valid_o = v_q[NS-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-2:0], cmd_valid_i};
  end

  logic [31:0] store_q [65536];
  logic [32:0] tab [idde_pkg::ExpTableSize+1];
  always_comb begin
    for (int unsigned i = 0; i <= idde_pkg::ExpTableSize; i++)
      tab[i] = idde_pkg::exp_entry(i);
  end

  logic [31:0] pix_q, pix2_q;
  logic        ok1_q, ok2_q, ok3_q, z1_q;
  logic [32:0] ea_q, eb_q, e_q;
  logic [31:0] fr_q;
  logic [63:0] pe_q;
  logic [64:0] mul_ab;
  logic [95:0] dd;
  assign mul_ab = 65'((ea_q - eb_q) * {1'b0, fr_q}) ;
  assign dd = 96'(pe_q[31:0]) * 96'(cfg_i.density_norm);

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && adv && !cmd_i.is_query) store_q[cmd_i.addr] <= cmd_i.wdata;
    if (adv) begin
      pix_q <= store_q[cmd_i.addr];
      ok1_q <= cmd_i.is_query && cmd_i.in_image;
      z1_q  <= cmd_i.ezero;
      ea_q  <= tab[{1'b0, cmd_i.eidx}];
      eb_q  <= tab[{1'b0, cmd_i.eidx} + 9'd1];
      fr_q  <= cmd_i.efrac;
      ok2_q <= ok1_q;
      pix2_q <= pix_q;
      e_q   <= z1_q ? 33'd0 : ea_q - 33'(mul_ab >> 32);
      ok3_q <= ok2_q;
      pe_q  <= (64'(pix2_q) * 64'(e_q)) >> 32;
      inside_o  <= ok3_q;
      density_o <= !ok3_q ? 48'd0 : ((dd >> 16) > 96'hFFFF_FFFF_FFFF) ?
                   48'hFFFF_FFFF_FFFF : 48'(dd >> 16);
    end
  end
endmodule
`default_nettype wire

>>> tb/idde_checker.sv
// Scoreboard for the disk density evaluator: watches the config, input and
// output channels, predicts each result and compares. Depends on idde_pkg.
`default_nettype none
module idde_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire logic [143:0] in_data_i,
  input  wire logic         in_func_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  wire logic [47:0]  out_data_i,
  input  wire logic         out_inside_i,
  output int                errors_o,
  output int                pending_o
);
  typedef struct packed {
    logic [47:0] density;
    logic        in_img;
  } dens_res_t;

  dens_res_t      dens_q[$];
  logic [31:0]    pix_mem [0:65535];
  logic [63:0]    exp_tab [0:idde_pkg::ExpTableSize];
  idde_pkg::cfg_t cfg;

  initial begin
    logic [63:0] h, sum, term, r;
    h = ((64'(idde_pkg::ExpSpan) << 32) / 64'(idde_pkg::ExpTableSize)) >> 1;
    sum = 64'd1 << 32;
    term = sum;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * h) >> 32) / 64'(k);
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    r = (sum * sum + 64'h8000_0000) >> 32;
    exp_tab[0] = 64'd1 << 32;
    for (int k = 1; k <= idde_pkg::ExpTableSize; k++)
      exp_tab[k] = (exp_tab[k-1] * r + 64'h8000_0000) >> 32;
  end

  // floor(v * inv / 2^32 + c / 2^16), arithmetic shifts give the floor
  function automatic longint pix_coord(longint v, logic [31:0] inv, logic [24:0] c);
    longint hi, lo, acc;
    hi = longint'(inv[31:16]);
    lo = longint'(inv[15:0]);
    acc = v * hi + longint'(c) + ((v * lo) >>> 16);
    return acc >>> 16;
  endfunction

  function automatic logic [63:0] decay(logic [63:0] t);
    logic [63:0] p, frac, a, b;
    int unsigned k;
    if (t >= (64'(idde_pkg::ExpSpan) << 32)) return 64'd0;
    p = t * 64'(idde_pkg::ExpTableSize) / 64'(idde_pkg::ExpSpan);
    k = p[63:32];
    if (k >= idde_pkg::ExpTableSize) return 64'd0;
    frac = {32'd0, p[31:0]};
    a = exp_tab[k];
    b = exp_tab[k+1];
    return a - (((a - b) * frac) >> 32);
  endfunction

  function automatic dens_res_t eval_density(logic [143:0] d);
    longint x, y, z, xp, xr, yr, col, row;
    logic [63:0] az, e, pe, dn;
    logic [15:0] addr;
    dens_res_t res;
    res = '0;
    x = longint'($signed(d[79:48]));
    y = longint'($signed(d[111:80]));
    z = longint'($signed(d[143:112]));
    xp = (x * longint'(cfg.cos_tilt)) >>> 14;
    xr = (longint'(cfg.sin_angle) * xp + longint'(cfg.cos_angle) * y) >>> 14;
    yr = (longint'(cfg.sin_angle) * y - longint'(cfg.cos_angle) * xp) >>> 14;
    col = pix_coord(xr, cfg.inv_pixel_size, cfg.center_col);
    row = pix_coord(yr, cfg.inv_pixel_size, cfg.center_row);
    if (col < 0 || col >= longint'(idde_pkg::ImageWidth) || row < 0 ||
        row >= longint'(idde_pkg::ImageHeight)) return res;
    addr = 16'(col + longint'(idde_pkg::ImageWidth) * row);
    az = (z < 0) ? 64'(-z) : 64'(z);
    e = decay(az * 64'(cfg.inv_height_scale));
    pe = (64'(pix_mem[addr]) * e) >> 32;
    dn = (pe * 64'(cfg.density_norm)) >> 16;
    if (dn > 64'hFFFF_FFFF_FFFF) dn = 64'hFFFF_FFFF_FFFF;
    res.density = dn[47:0];
    res.in_img = 1'b1;
    return res;
  endfunction

  assign pending_o = dens_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg <= '{sin_angle: 16'sd0, cos_angle: 16'sd16384, cos_tilt: 15'd16384,
               inv_pixel_size: 32'd65536, center_col: 25'd8388608,
               center_row: 25'd8388608, inv_height_scale: 32'd65536,
               density_norm: 32'd65536};
      errors_o <= 0;
      dens_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (idde_pkg::reg_idx_e'(cfg_index_i))
          idde_pkg::RegSinAngle:  cfg.sin_angle        <= cfg_data_i[15:0];
          idde_pkg::RegCosAngle:  cfg.cos_angle        <= cfg_data_i[15:0];
          idde_pkg::RegCosTilt:   cfg.cos_tilt         <= cfg_data_i[14:0];
          idde_pkg::RegInvPixel:  cfg.inv_pixel_size   <= cfg_data_i;
          idde_pkg::RegCenterCol: cfg.center_col       <= cfg_data_i[24:0];
          idde_pkg::RegCenterRow: cfg.center_row       <= cfg_data_i[24:0];
          idde_pkg::RegInvHeight: cfg.inv_height_scale <= cfg_data_i;
          idde_pkg::RegDensNorm:  cfg.density_norm     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!in_func_i) begin
          pix_mem[in_data_i[15:0]] = in_data_i[47:16];
          dens_q.push_back('0);
        end else begin
          dens_q.push_back(eval_density(in_data_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (dens_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual density %h inside %b",
                   $time, out_data_i, out_inside_i);
          errors_o <= errors_o + 1;
        end else begin
          dens_res_t want;
          want = dens_q.pop_front();
          if (want.density !== out_data_i || want.in_img !== out_inside_i) begin
            $display("%0t: expected density %h inside %b, actual density %h inside %b",
                     $time, want.density, want.in_img, out_data_i, out_inside_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench top for image_disk_density_eval: clock, reset, stimulus with
// random gaps and stalls, and the verdict. Depends on idde_pkg, idde_checker.
`default_nettype none
module tb;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           errors, pending;
  bit           no_idle = 1'b0;
  int           stall_left = 0;
  int           sent_items = 0;
  bit           written [65536];
  // register values currently loaded, used to steer queries onto written pixels
  logic [31:0]  regs_now [8] = '{32'd0, 32'd16384, 32'd16384, 32'd65536, 32'd8388608,
                                 32'd8388608, 32'd65536, 32'd65536};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  image_disk_density_eval uut (.*);

  idde_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .in_func_i(s_axis_tuser), .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata), .out_inside_i(m_axis_tuser),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      m_axis_tready <= 1'b1;
    end
  end

  function automatic longint to_px(longint v, logic [31:0] inv, logic [24:0] c);
    longint acc;
    acc = v * longint'(inv[31:16]) + longint'(c) + ((v * longint'(inv[15:0])) >>> 16);
    return acc >>> 16;
  endfunction

  // store address a query lands on, or -1 when it falls outside the image
  function automatic int pixel_of(logic [31:0] x, logic [31:0] y);
    longint sa, ca, xs, ys, xp, xr, yr, col, row;
    sa = longint'($signed(regs_now[0][15:0]));
    ca = longint'($signed(regs_now[1][15:0]));
    xs = longint'($signed(x));
    ys = longint'($signed(y));
    xp = (xs * longint'(regs_now[2][14:0])) >>> 14;
    xr = (sa * xp + ca * ys) >>> 14;
    yr = (sa * ys - ca * xp) >>> 14;
    col = to_px(xr, regs_now[3], regs_now[4][24:0]);
    row = to_px(yr, regs_now[3], regs_now[5][24:0]);
    if (col < 0 || col >= longint'(idde_pkg::ImageWidth) || row < 0 ||
        row >= longint'(idde_pkg::ImageHeight)) return -1;
    return int'(col + longint'(idde_pkg::ImageWidth) * row);
  endfunction

  task automatic send_item(bit func, logic [15:0] addr, logic [31:0] pix,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {z, y, x, pix, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items = sent_items + 1;
  endtask

  task automatic write_pixel(logic [15:0] addr, logic [31:0] pix);
    written[addr] = 1'b1;
    send_item(1'b0, addr, pix, $urandom, $urandom, $urandom);
  endtask

  // a query never reads a pixel that was not written first
  task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int p;
    p = pixel_of(x, y);
    if (p >= 0 && !written[p]) write_pixel(16'(p), $urandom);
    send_item(1'b1, 16'($urandom), $urandom, x, y, z);
  endtask

  // config writes only once the pipeline has drained
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] vals [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idde_pkg::reg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    regs_now = vals;
  endtask

  function automatic logic [31:0] coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 32'($urandom_range(0, 320 << 16)) - 32'(160 << 16);
    if (r < 9) return 32'($urandom_range(0, 4000 << 16)) - 32'(2000 << 16);
    return $urandom;
  endfunction

  function automatic logic [31:0] height();
    logic [31:0] z;
    if ($urandom_range(0, 9) == 0) return $urandom;
    z = $urandom_range(0, 20 << 16);
    return $urandom_range(0, 1) ? -z : z;
  endfunction

  initial begin
    logic [31:0] regs [8];
    int target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, image edges, large exponent
    write_pixel(16'h0000, 32'h0000_0000);
    write_pixel(16'hFFFF, 32'hFFFF_FFFF);
    write_pixel(16'h8080, 32'hFFFF_FFFF);
    query(32'd0, 32'd0, 32'd0);
    query(32'd0, 32'd0, 32'h0000_8000);
    query(32'd0, 32'd0, 32'hFFFF_8000);
    query(32'd0, 32'd0, 32'(16 << 16));
    query(32'd0, 32'd0, 32'(16 << 16) - 1);
    query(32'd0, 32'd0, 32'h8000_0000);
    query(32'd0, -32'(128 << 16), 32'd0);
    query(32'd0, 32'(128 << 16) - 1, 32'd0);
    query(32'd0, 32'(128 << 16), 32'd0);
    query(32'd0, -32'(128 << 16) - 1, 32'd0);
    query(32'(128 << 16), 32'd0, 32'd0);
    query(-32'(128 << 16), 32'd0, 32'd0);
    query(32'(128 << 16) - 1, 32'(128 << 16) - 1, 32'd0);
    query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: regs = '{32'd0, 32'd16384, 32'd16384, 32'd65536, 32'd8388608, 32'd8388608,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF};
        1: regs = '{-32'd16384, 32'd0, 32'd0, 32'd65536, 32'd8388608, 32'd8388608,
                    32'd0, 32'd65536};
        2: regs = '{32'd16384, -32'd16384, 32'd16384, 32'hFFFF_FFFF, 32'd0, 32'd16777216,
                    32'd65536, 32'd0};
        3: regs = '{32'd0, 32'd16384, 32'd16384, 32'd0, 32'd0, 32'd0, 32'd1, 32'd65536};
        4: regs = '{32'hFFFF, 32'h7FFF, 32'h7FFF, 32'd2048, 32'h1FF_FFFF, 32'h1FF_FFFF,
                    32'd65536, 32'hFFFF_FFFF};
        5, 6: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom};
        default: begin
          regs[0] = 32'($urandom_range(0, 32768)) - 32'd16384;
          regs[1] = 32'($urandom_range(0, 32768)) - 32'd16384;
          regs[2] = $urandom_range(0, 16384);
          regs[3] = $urandom_range(32'h4000, 32'h40000);
          regs[4] = $urandom_range(0, 16777216);
          regs[5] = $urandom_range(0, 16777216);
          regs[6] = $urandom_range(0, 32'h40000);
          regs[7] = $urandom;
        end
      endcase
      set_regs(regs);
      no_idle = (ph == 8);
      target = sent_items + 145;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) < 3) write_pixel(16'($urandom), $urandom);
        else query(coord(), coord(), height());
      end
      no_idle = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
